// File: rtl/core/hbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbt_pkg
// Shared field widths, command codes and status codes of the bucket table.
// ----------------------------------------------------------------------------
package hbt_pkg;

	localparam int KEY_W = 64;
	localparam int VAL_W = 32;
	localparam int CNT_W = 6;

	// Command codes
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_SPLIT  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

endpackage

// File: rtl/core/hbt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module hbt_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on enable, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/hash_bucket_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_bucket_table
// One bucket of an extendible hash table: lookup, insert, remove and split
// over up to ENTRIES key/value pairs kept densely in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with cmd, key, value, sel_mask and sel_pattern; the item
//   is taken at an edge where busy is low. Each result shows on the result
//   ports for one cycle with done high; the receiver takes it there and then.
//   last marks the final result of an item.
// Commands:
//   insert : result in the cycle after acceptance, busy never rises, so an
//            insert may follow in the next cycle.
//   lookup : a scan over the entries held, ending early on the first hit.
//   remove : scan, read of the last slot, write back.
//   split  : a counting pass over the RAM sets the final entry count, then a
//            second pass emits moved entries and compacts the kept ones. An
//            empty split emits one result.
//   The scan reads one RAM entry per cycle; the single read port sets the rate.
// Reset: the entry count clears, RAM contents are left as they are and are
//   never used above the count. Results cannot be stalled.
// ----------------------------------------------------------------------------
module hash_bucket_table #(
	parameter int ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [63:0] key,
	input  logic [31:0] value,
	input  logic [63:0] sel_mask,
	input  logic [63:0] sel_pattern,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] found_value,
	output logic [63:0] moved_key,
	output logic [31:0] moved_value,
	output logic        moved_valid,
	output logic [5:0]  entry_count,
	output logic        last
);

	localparam int KW = hbt_pkg::KEY_W;
	localparam int VW = hbt_pkg::VAL_W;
	localparam int OW = hbt_pkg::CNT_W;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_REM_SCAN,
		S_REM_RD,
		S_REM_WR,
		S_SPL_CNT,
		S_SPL_MOVE
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   ptr_q;
	logic [CW-1:0]   keep_q;
	logic [CW-1:0]   moved_q;
	logic [CW-1:0]   emit_q;
	logic [CW-1:0]   wr_q;
	logic [AW-1:0]   found_q;
	logic [AW-1:0]   idx_s1;
	logic            vld_s1;
	logic [KW-1:0]   key_q;
	logic [KW-1:0]   mask_q;
	logic [KW-1:0]   suffix_q;

	logic            done_q;
	logic [1:0]      status_q;
	logic [VW-1:0]   found_val_q;
	logic [KW-1:0]   mkey_q;
	logic [VW-1:0]   mval_q;
	logic            mvalid_q;
	logic [OW-1:0]   ecount_q;
	logic            last_q;

	logic                scanning;
	logic                rd_issue;
	logic                scan_end;
	logic [CW-1:0]       cnt_m1;
	logic [CW-1:0]       cnt_p1;
	logic [CW-1:0]       emit_nx;
	logic                has_room;
	logic [KW+VW-1:0]    rdata;
	logic [KW-1:0]       rd_key;
	logic [VW-1:0]       rd_val;
	logic                hit_key;
	logic                hit_split;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [KW+VW-1:0]    ram_wdata;
	logic [AW-1:0]       ram_raddr;

	// Scan control
	assign scanning = (state_q == S_LOOK) || (state_q == S_REM_SCAN) ||
	                  (state_q == S_SPL_CNT) || (state_q == S_SPL_MOVE);
	assign rd_issue = scanning && (ptr_q < cnt_q);
	assign scan_end = (ptr_q == cnt_q) && !vld_s1;
	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_p1   = cnt_q + CW'(1);
	assign emit_nx  = emit_q + CW'(1);
	assign has_room = cnt_q < CW'(ENTRIES);

	// Compare the entry read last cycle
	assign rd_key    = rdata[KW+VW-1:VW];
	assign rd_val    = rdata[VW-1:0];
	assign hit_key   = rd_key == key_q;
	assign hit_split = (rd_key & mask_q) == suffix_q;

	// RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_q[AW-1:0];
		ram_wdata = rdata;
		ram_raddr = ptr_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				ram_we    = start && (cmd == hbt_pkg::CMD_INSERT) && has_room;
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = {key, value};
			end
			S_REM_RD: begin
				ram_raddr = cnt_m1[AW-1:0];
			end
			S_REM_WR: begin
				ram_we    = 1'b1;
				ram_waddr = found_q;
			end
			S_SPL_MOVE: begin
				ram_we    = vld_s1 && !hit_split;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	hbt_ram #(
		.WIDTH(KW + VW),
		.DEPTH(ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	// Sequencer, scan pointer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			keep_q      <= '0;
			moved_q     <= '0;
			emit_q      <= '0;
			wr_q        <= '0;
			found_q     <= '0;
			idx_s1      <= '0;
			vld_s1      <= 1'b0;
			key_q       <= '0;
			mask_q      <= '0;
			suffix_q    <= '0;
			done_q      <= 1'b0;
			status_q    <= hbt_pkg::ST_OK;
			found_val_q <= '0;
			mkey_q      <= '0;
			mval_q      <= '0;
			mvalid_q    <= 1'b0;
			ecount_q    <= '0;
			last_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= rd_issue;
			if (rd_issue) begin
				ptr_q  <= ptr_q + CW'(1);
				idx_s1 <= ptr_q[AW-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q    <= key;
						mask_q   <= sel_mask;
						suffix_q <= sel_pattern;
						ptr_q    <= '0;
						keep_q   <= '0;
						moved_q  <= '0;
						emit_q   <= '0;
						wr_q     <= '0;
						unique case (cmd)
							hbt_pkg::CMD_LOOKUP: state_q <= S_LOOK;
							hbt_pkg::CMD_REMOVE: state_q <= S_REM_SCAN;
							hbt_pkg::CMD_SPLIT:  state_q <= S_SPL_CNT;
							hbt_pkg::CMD_INSERT: begin
								// Append at the end, or report full
								done_q      <= 1'b1;
								found_val_q <= '0;
								mkey_q      <= '0;
								mval_q      <= '0;
								mvalid_q    <= 1'b0;
								last_q      <= 1'b1;
								if (has_room) begin
									cnt_q    <= cnt_p1;
									status_q <= hbt_pkg::ST_OK;
									ecount_q <= OW'(cnt_p1);
								end else begin
									status_q <= hbt_pkg::ST_FULL;
									ecount_q <= OW'(cnt_q);
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_LOOK: begin
					// Stop at the first hit, or report a miss at the end
					if ((vld_s1 && hit_key) || scan_end) begin
						state_q     <= S_IDLE;
						done_q      <= 1'b1;
						mkey_q      <= '0;
						mval_q      <= '0;
						mvalid_q    <= 1'b0;
						ecount_q    <= OW'(cnt_q);
						last_q      <= 1'b1;
						if (vld_s1 && hit_key) begin
							status_q    <= hbt_pkg::ST_OK;
							found_val_q <= rd_val;
						end else begin
							status_q    <= hbt_pkg::ST_MISS;
							found_val_q <= '0;
						end
					end
				end
				S_REM_SCAN: begin
					if (vld_s1 && hit_key) begin
						found_q <= idx_s1;
						state_q <= S_REM_RD;
					end else if (scan_end) begin
						state_q     <= S_IDLE;
						done_q      <= 1'b1;
						status_q    <= hbt_pkg::ST_MISS;
						found_val_q <= '0;
						mkey_q      <= '0;
						mval_q      <= '0;
						mvalid_q    <= 1'b0;
						ecount_q    <= OW'(cnt_q);
						last_q      <= 1'b1;
					end
				end
				S_REM_RD: begin
					// Wait for the last slot to come out of the RAM
					state_q <= S_REM_WR;
				end
				S_REM_WR: begin
					// Last entry fills the hole
					state_q     <= S_IDLE;
					cnt_q       <= cnt_m1;
					done_q      <= 1'b1;
					status_q    <= hbt_pkg::ST_OK;
					found_val_q <= '0;
					mkey_q      <= '0;
					mval_q      <= '0;
					mvalid_q    <= 1'b0;
					ecount_q    <= OW'(cnt_m1);
					last_q      <= 1'b1;
				end
				S_SPL_CNT: begin
					// First pass: count kept and moved entries
					if (vld_s1) begin
						if (hit_split) begin
							moved_q <= moved_q + CW'(1);
						end else begin
							keep_q <= keep_q + CW'(1);
						end
					end
					if (scan_end) begin
						if (moved_q == '0) begin
							state_q     <= S_IDLE;
							done_q      <= 1'b1;
							status_q    <= hbt_pkg::ST_OK;
							found_val_q <= '0;
							mkey_q      <= '0;
							mval_q      <= '0;
							mvalid_q    <= 1'b0;
							ecount_q    <= OW'(keep_q);
							last_q      <= 1'b1;
						end else begin
							ptr_q   <= '0;
							state_q <= S_SPL_MOVE;
						end
					end
				end
				S_SPL_MOVE: begin
					// Second pass: emit moved entries, compact the rest
					if (vld_s1) begin
						if (hit_split) begin
							emit_q      <= emit_nx;
							done_q      <= 1'b1;
							status_q    <= hbt_pkg::ST_OK;
							found_val_q <= '0;
							mkey_q      <= rd_key;
							mval_q      <= rd_val;
							mvalid_q    <= 1'b1;
							ecount_q    <= OW'(keep_q);
							last_q      <= emit_nx == moved_q;
						end else begin
							wr_q <= wr_q + CW'(1);
						end
					end
					if (scan_end) begin
						cnt_q   <= keep_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign found_value = found_val_q;
	assign moved_key   = mkey_q;
	assign moved_value = mval_q;
	assign moved_valid = mvalid_q;
	assign entry_count = ecount_q;
	assign last        = last_q;

	// Count never exceeds the bucket size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(ENTRIES))
		else $error("entry count beyond bucket size");

	// Compaction never overwrites a slot not yet read
	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPL_MOVE) && ram_we |-> wr_q <= CW'(idx_s1))
		else $error("compaction write ahead of the scan");

	// A result that is not the last one is followed by more work
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !last_q |=> busy)
		else $error("non-final result with the block idle");

	// Moved entries always carry a good status
	a_moved_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && mvalid_q |-> status_q == hbt_pkg::ST_OK)
		else $error("moved entry with a bad status");

endmodule

// File: sim/tb_hash_bucket_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_bucket_table
// Self-checking bench for one hash bucket: a table of directed items walks
// the edge cases, then random lookup/insert/remove/split traffic runs in
// three phases of sender idling. A bucket predictor computes every result.
// ----------------------------------------------------------------------------
module tb_hash_bucket_table;

	localparam int          SLOTS  = 32;
	localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_value;
		logic [63:0] moved_key;
		logic [31:0] moved_value;
		logic        moved_valid;
		logic [5:0]  entry_count;
		logic        last;
	} result_t;

	typedef struct {
		logic [1:0]  op;
		logic [63:0] key;
		logic [31:0] value;
		logic [63:0] mask;
		logic [63:0] suffix;
		bit          typed;
		logic [1:0]  t_status;
		logic [31:0] t_found;
		logic [5:0]  t_count;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = hbt_pkg::CMD_LOOKUP;
	logic [63:0] key = '0;
	logic [31:0] value = '0;
	logic [63:0] sel_mask = '0;
	logic [63:0] sel_pattern = '0;
	logic        done;
	logic [1:0]  status;
	logic [31:0] found_value;
	logic [63:0] moved_key;
	logic [31:0] moved_value;
	logic        moved_valid;
	logic [5:0]  entry_count;
	logic        last;

	// typed expectation that rides along with a directed item
	bit          row_typed = 1'b0;
	result_t     row_exp = '0;

	// bucket predictor state
	logic [63:0] bkt_keys [SLOTS];
	logic [31:0] bkt_vals [SLOTS];
	int          bkt_count = 0;

	result_t     pending_results [$];
	logic [63:0] key_pool [14];
	int          idle_pct = 7;
	int          errors = 0;

	step_t dir_rows [0:20] = '{
		'{hbt_pkg::CMD_LOOKUP, 64'h0, 32'h0, 64'h0, 64'h0,
			1'b1, hbt_pkg::ST_MISS, 32'h0, 6'd0},
		'{hbt_pkg::CMD_REMOVE, ONES64, 32'h0, 64'h0, 64'h0,
			1'b1, hbt_pkg::ST_MISS, 32'h0, 6'd0},
		'{hbt_pkg::CMD_SPLIT, 64'h0, 32'h0, 64'h0, 64'h0,
			1'b1, hbt_pkg::ST_OK, 32'h0, 6'd0},
		'{hbt_pkg::CMD_INSERT, 64'h0, 32'h0, 64'h0, 64'h0,
			1'b1, hbt_pkg::ST_OK, 32'h0, 6'd1},
		'{hbt_pkg::CMD_INSERT, ONES64, 32'hFFFF_FFFF, 64'h0, 64'h0,
			1'b1, hbt_pkg::ST_OK, 32'h0, 6'd2},
		'{hbt_pkg::CMD_INSERT, 64'h0, 32'h1234_5678, 64'h0, 64'h0,
			1'b1, hbt_pkg::ST_OK, 32'h0, 6'd3},
		'{hbt_pkg::CMD_LOOKUP, 64'h0, 32'h0, 64'h0, 64'h0,
			1'b1, hbt_pkg::ST_OK, 32'h0, 6'd3},
		'{hbt_pkg::CMD_LOOKUP, ONES64, 32'h0, 64'h0, 64'h0,
			1'b1, hbt_pkg::ST_OK, 32'hFFFF_FFFF, 6'd3},
		'{hbt_pkg::CMD_REMOVE, 64'h0, 32'h0, 64'h0, 64'h0,
			1'b1, hbt_pkg::ST_OK, 32'h0, 6'd2},
		'{hbt_pkg::CMD_LOOKUP, 64'h0, 32'h0, 64'h0, 64'h0,
			1'b1, hbt_pkg::ST_OK, 32'h1234_5678, 6'd2},
		'{hbt_pkg::CMD_LOOKUP, 64'h5555_5555_5555_5555, 32'h0, 64'h0, 64'h0,
			1'b1, hbt_pkg::ST_MISS, 32'h0, 6'd2},
		'{hbt_pkg::CMD_INSERT, 64'h8000_0000_0000_00A5, 32'h8000_0001, 64'h0, 64'h0,
			1'b0, hbt_pkg::ST_OK, 32'h0, 6'd0},
		'{hbt_pkg::CMD_INSERT, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF, 64'h0, 64'h0,
			1'b0, hbt_pkg::ST_OK, 32'h0, 6'd0},
		'{hbt_pkg::CMD_SPLIT, 64'h0, 32'h0, 64'h0, 64'h1,
			1'b1, hbt_pkg::ST_OK, 32'h0, 6'd4},
		'{hbt_pkg::CMD_SPLIT, 64'h0, 32'h0, ONES64, ONES64,
			1'b0, hbt_pkg::ST_OK, 32'h0, 6'd0},
		'{hbt_pkg::CMD_SPLIT, 64'h0, 32'h0, 64'hFF, 64'hA5,
			1'b0, hbt_pkg::ST_OK, 32'h0, 6'd0},
		'{hbt_pkg::CMD_REMOVE, 64'h0123_4567_89AB_CDEF, 32'h0, 64'h0, 64'h0,
			1'b0, hbt_pkg::ST_OK, 32'h0, 6'd0},
		'{hbt_pkg::CMD_SPLIT, 64'h0, 32'h0, 64'h0, 64'h0,
			1'b0, hbt_pkg::ST_OK, 32'h0, 6'd0},
		'{hbt_pkg::CMD_LOOKUP, 64'h0, 32'h0, 64'h0, 64'h0,
			1'b1, hbt_pkg::ST_MISS, 32'h0, 6'd0},
		'{hbt_pkg::CMD_INSERT, ONES64, 32'h0, 64'h0, 64'h0,
			1'b0, hbt_pkg::ST_OK, 32'h0, 6'd0},
		'{hbt_pkg::CMD_REMOVE, ONES64, 32'h0, 64'h0, 64'h0,
			1'b0, hbt_pkg::ST_OK, 32'h0, 6'd0}
	};

	hash_bucket_table #(
		.ENTRIES(SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.key(key),
		.value(value),
		.sel_mask(sel_mask),
		.sel_pattern(sel_pattern),
		.done(done),
		.status(status),
		.found_value(found_value),
		.moved_key(moved_key),
		.moved_value(moved_value),
		.moved_valid(moved_valid),
		.entry_count(entry_count),
		.last(last)
	);

	always #5 clk = ~clk;

	// Print one mismatch line and count it
	task automatic report_mismatch(input string field, input logic [63:0] got,
		input logic [63:0] want);
		errors++;
		$display("%0t ns: mismatch on %s: got %h, want %h", $time, field, got, want);
	endtask

	// Apply one item to the predicted bucket and queue the results it causes
	task automatic bucket_apply(input logic [1:0] op, input logic [63:0] k,
		input logic [31:0] v, input logic [63:0] m, input logic [63:0] s);
		logic [63:0] mk [SLOTS];
		logic [31:0] mv [SLOTS];
		int          hit;
		int          moved_n;
		int          keep_n;
		result_t     r;
		r = '0;
		r.last = 1'b1;
		hit = -1;
		for (int i = bkt_count - 1; i >= 0; i--) begin
			if (bkt_keys[i] == k) hit = i;
		end
		case (op)
			hbt_pkg::CMD_LOOKUP: begin
				if (hit >= 0) begin
					r.status = hbt_pkg::ST_OK;
					r.found_value = bkt_vals[hit];
				end else begin
					r.status = hbt_pkg::ST_MISS;
				end
			end
			hbt_pkg::CMD_INSERT: begin
				if (bkt_count < SLOTS) begin
					bkt_keys[bkt_count] = k;
					bkt_vals[bkt_count] = v;
					bkt_count++;
					r.status = hbt_pkg::ST_OK;
				end else begin
					r.status = hbt_pkg::ST_FULL;
				end
			end
			hbt_pkg::CMD_REMOVE: begin
				if (hit >= 0) begin
					bkt_count--;
					bkt_keys[hit] = bkt_keys[bkt_count];
					bkt_vals[hit] = bkt_vals[bkt_count];
					r.status = hbt_pkg::ST_OK;
				end else begin
					r.status = hbt_pkg::ST_MISS;
				end
			end
			default: begin
				// move matching entries out, compact the kept ones in order
				moved_n = 0;
				keep_n = 0;
				for (int i = 0; i < bkt_count; i++) begin
					if ((bkt_keys[i] & m) == s) begin
						mk[moved_n] = bkt_keys[i];
						mv[moved_n] = bkt_vals[i];
						moved_n++;
					end else begin
						bkt_keys[keep_n] = bkt_keys[i];
						bkt_vals[keep_n] = bkt_vals[i];
						keep_n++;
					end
				end
				bkt_count = keep_n;
				r.status = hbt_pkg::ST_OK;
				for (int j = 0; j < moved_n; j++) begin
					r.moved_key = mk[j];
					r.moved_value = mv[j];
					r.moved_valid = 1'b1;
					r.last = (j == moved_n - 1);
					r.entry_count = bkt_count[5:0];
					pending_results.push_back(r);
				end
				if (moved_n > 0) return;
			end
		endcase
		r.entry_count = bkt_count[5:0];
		pending_results.push_back(r);
	endtask

	// Check results against the oldest expectation, then predict accepted items
	always @(posedge clk) begin : monitor
		result_t want;
		if (done === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", 64'(status), '0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", 64'(status), 64'(want.status));
				if (found_value !== want.found_value)
					report_mismatch("found_value", 64'(found_value),
						64'(want.found_value));
				if (moved_key !== want.moved_key)
					report_mismatch("moved_key", moved_key, want.moved_key);
				if (moved_value !== want.moved_value)
					report_mismatch("moved_value", 64'(moved_value),
						64'(want.moved_value));
				if (moved_valid !== want.moved_valid)
					report_mismatch("moved_valid", 64'(moved_valid),
						64'(want.moved_valid));
				if (entry_count !== want.entry_count)
					report_mismatch("entry_count", 64'(entry_count),
						64'(want.entry_count));
				if (last !== want.last)
					report_mismatch("last", 64'(last), 64'(want.last));
			end
		end
		if (start === 1'b1 && busy === 1'b0) begin
			bucket_apply(cmd, key, value, sel_mask, sel_pattern);
			// a typed row causes one result; its typed values replace the prediction
			if (row_typed) pending_results[pending_results.size() - 1] = row_exp;
		end
	end

	// Drive one item, with a random idle gap ahead of it; return at acceptance
	task automatic send_item(input logic [1:0] op, input logic [63:0] k,
		input logic [31:0] v, input logic [63:0] m, input logic [63:0] s,
		input bit typed, input result_t texp);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct && gap < 60) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		key <= k;
		value <= v;
		sel_mask <= m;
		sel_pattern <= s;
		row_typed <= typed;
		row_exp <= texp;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_key();
		if ($urandom_range(99) < 75) return key_pool[$urandom_range(13)];
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_mask();
		case ($urandom_range(5))
			0: return 64'd1 << $urandom_range(63);
			1: return (64'd1 << $urandom_range(4, 1)) - 64'd1;
			2: return {$urandom, $urandom};
			3: return '0;
			4: return ONES64;
			default: return {$urandom, $urandom} & {$urandom, $urandom};
		endcase
	endfunction

	// Hold off the sender until every outstanding result has come back
	task automatic drain_bucket();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	initial begin : stimulus
		result_t     texp;
		logic [63:0] m;
		logic [63:0] s;
		int          r;
		for (int i = 0; i < 12; i++) key_pool[i] = {$urandom, $urandom};
		key_pool[12] = '0;
		key_pool[13] = ONES64;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: extremes, every command, duplicates, empty and null splits
		foreach (dir_rows[i]) begin
			texp = '0;
			texp.status = dir_rows[i].t_status;
			texp.found_value = dir_rows[i].t_found;
			texp.entry_count = dir_rows[i].t_count;
			texp.last = 1'b1;
			send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].value,
				dir_rows[i].mask, dir_rows[i].suffix, dir_rows[i].typed, texp);
		end

		// random traffic: busy sender, mostly idle sender, then back to back
		texp = '0;
		for (int ph = 0; ph < 3; ph++) begin
			drain_bucket();
			idle_pct = (ph == 0) ? 7 : (ph == 1) ? 84 : 0;
			// empty the bucket, then fill it past full
			send_item(hbt_pkg::CMD_SPLIT, '0, '0, '0, '0, 1'b0, texp);
			for (int n = 0; n < 34; n++) begin
				send_item(hbt_pkg::CMD_INSERT, pick_key(), $urandom,
					{$urandom, $urandom}, {$urandom, $urandom}, 1'b0, texp);
			end
			for (int n = 0; n < 115; n++) begin
				r = $urandom_range(99);
				if (r < 40) begin
					send_item(hbt_pkg::CMD_INSERT, pick_key(), $urandom,
						{$urandom, $urandom}, {$urandom, $urandom}, 1'b0, texp);
				end else if (r < 65) begin
					send_item(hbt_pkg::CMD_LOOKUP, pick_key(), $urandom,
						{$urandom, $urandom}, {$urandom, $urandom}, 1'b0, texp);
				end else if (r < 85) begin
					send_item(hbt_pkg::CMD_REMOVE, pick_key(), $urandom,
						{$urandom, $urandom}, {$urandom, $urandom}, 1'b0, texp);
				end else begin
					m = pick_mask();
					s = ($urandom_range(99) < 75) ? (pick_key() & m) : {$urandom, $urandom};
					send_item(hbt_pkg::CMD_SPLIT, {$urandom, $urandom}, $urandom, m, s,
						1'b0, texp);
				end
			end
		end

		// wait out the last results, then allow for any stray ones
		drain_bucket();
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Stop a hung run
	initial begin : watchdog
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/hbt_pkg.sv
rtl/core/hbt_ram.sv
rtl/core/hash_bucket_table.sv
sim/tb_hash_bucket_table.sv
